// ===== design/conv5_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package conv5_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W     = 8;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;
  localparam int COEF_ROWS = 5;
  localparam int COEF_W    = 40;
  localparam int LS_W      = 32;
  localparam int SUM_W     = 21;
  localparam int DIVD_W    = 20;
  localparam int NORM_W    = 8;
  localparam int IMG_W_W   = 11;
  localparam int IMG_H_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF4  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NORM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

  typedef logic [COEF_ROWS-1:0][COEF_W-1:0] coef_bank_t;

  typedef struct packed {
    logic shift;
    logic start;
  } win_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_DIV,
    S_HOLD
  } state_t;

endpackage
`default_nettype wire

// ===== design/conv5_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface conv5_pix_if
  import conv5_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface conv5_res_if
  import conv5_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PIX_W-1:0]     pixel_out;
  logic [OUT_COL_W-1:0] out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic                 end_of_frame;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input end_of_frame, output ready);
endinterface
`default_nettype wire

// ===== design/conv5_line_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module conv5_line_mem
  import conv5_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output logic      [LS_W-1:0] rd_data,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [LS_W-1:0] wr_data
);

  logic [LS_W-1:0] store_r [DEPTH];
  logic [LS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== design/conv5_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
module conv5_window
  import conv5_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire win_ctl_t                ctl,
  input  wire logic       [LS_W-1:0]   ls_word,
  input  wire logic       [PIX_W-1:0]  px,
  input  wire coef_bank_t              coef,
  output logic signed     [SUM_W-1:0]  sum,
  output logic                         done
);

  logic [4:0][4:0][PIX_W-1:0] win_r;
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SUM_W-1:0]    acc_nxt;
  logic [2:0]                 step_r;
  logic                       active_r;
  logic                       done_r;
  logic [4:0][PIX_W-1:0]      new_col;
  logic signed [8:0]          px_s [5];
  logic signed [7:0]          cf_s [5];
  logic signed [16:0]         prod [5];
  logic signed [SUM_W-1:0]    col_sum;

  assign new_col[0] = ls_word[31:24];
  assign new_col[1] = ls_word[23:16];
  assign new_col[2] = ls_word[15:8];
  assign new_col[3] = ls_word[7:0];
  assign new_col[4] = px;

  // column 0 of the rotating window meets coefficient column step_r
  always_comb begin
    col_sum = '0;
    for (int k = 0; k < 5; k++) begin
      px_s[k] = signed'({1'b0, win_r[k][0]});
      cf_s[k] = signed'(coef[k][{step_r, 3'b000} +: 8]);
      prod[k] = px_s[k] * cf_s[k];
      col_sum = col_sum + SUM_W'(prod[k]);
    end
    acc_nxt = acc_r + col_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
      step_r   <= '0;
      acc_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.shift) begin
        for (int k = 0; k < 5; k++) begin
          for (int m = 0; m < 4; m++) begin
            win_r[k][m] <= win_r[k][m+1];
          end
          win_r[k][4] <= new_col[k];
        end
        if (ctl.start) begin
          active_r <= 1'b1;
          step_r   <= '0;
          acc_r    <= '0;
        end
      end else if (active_r) begin
        for (int k = 0; k < 5; k++) begin
          for (int m = 0; m < 4; m++) begin
            win_r[k][m] <= win_r[k][m+1];
          end
          win_r[k][4] <= win_r[k][0];
        end
        acc_r  <= acc_nxt;
        step_r <= step_r + 3'd1;
        if (step_r == 3'd4) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  assign sum  = acc_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== design/conv5_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module conv5_div
  import conv5_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [SUM_W-1:0]  sum,
  input  wire logic        [NORM_W-1:0] divisor,
  output logic             [PIX_W-1:0]  q,
  output logic                          done
);

  localparam logic [3:0] DIV_CHECK = 4'd8;

  logic [DIVD_W-1:0] rem_r;
  logic [NORM_W-1:0] d_r;
  logic [PIX_W-1:0]  q_r;
  logic [3:0]        cnt_r;
  logic              active_r;
  logic              done_r;
  logic [DIVD_W-1:0] sat_lim;
  logic [DIVD_W-1:0] shifted;

  assign sat_lim = {4'b0000, d_r, 8'h00};
  assign shifted = DIVD_W'(d_r) << cnt_r[2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
      q_r      <= '0;
      rem_r    <= '0;
      d_r      <= 8'd1;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // a negative sum divides as zero and so gives zero
        rem_r    <= sum[SUM_W-1] ? '0 : sum[DIVD_W-1:0];
        d_r      <= (divisor == '0) ? NORM_W'(1) : divisor;
        q_r      <= '0;
        cnt_r    <= DIV_CHECK;
        active_r <= 1'b1;
      end else if (active_r) begin
        if (cnt_r == DIV_CHECK) begin
          if (rem_r >= sat_lim) begin
            q_r      <= '1;
            active_r <= 1'b0;
            done_r   <= 1'b1;
          end else begin
            cnt_r <= 4'd7;
          end
        end else begin
          if (rem_r >= shifted) begin
            rem_r            <= rem_r - shifted;
            q_r[cnt_r[2:0]]  <= 1'b1;
          end
          if (cnt_r == 4'd0) begin
            active_r <= 1'b0;
            done_r   <= 1'b1;
          end else begin
            cnt_r <= cnt_r - 4'd1;
          end
        end
      end
    end
  end

  assign q    = q_r;
  assign done = done_r;

endmodule
`default_nettype wire

// ===== design/conv5x5_normalized_filter.sv =====
// 5x5 normalized convolution over a raster-order stream of 8-bit grey pixels.
// in_pix carries one pixel per transfer; out_res carries the filtered value
// of the window centre with its column, row and an end-of-frame flag.
// Pixels in the first four rows or first four columns give no result.
// cfg_we/cfg_index/cfg_wdata write the coefficient rows, the divisor and the
// image size; write them only while the block is idle.
// Each pixel does a read-modify-write of the line store: a read on the input
// transfer and a write in the read state, after which a border pixel is done.
// A windowed pixel then runs a multiply-accumulate (one window column per
// cycle) and a restoring division (one quotient bit per cycle after a
// saturation check); no new pixel is taken until its division is done.
// A finished result sits in the output register; the next pixel is taken
// while it waits. If the receiver stalls and a second result is ready, the
// block holds it and takes no pixel until the output register is free.
// Synchronous reset clears the counters, the window, the state and the
// output valid, sets config defaults; the line store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module conv5x5_normalized_filter
  import conv5_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  conv5_pix_if.sink                  in_pix,
  conv5_res_if.source                out_res,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  state_t state_r;
  state_t state_nxt;

  coef_bank_t          coef_r;
  logic [NORM_W-1:0]   norm_r;
  logic [IMG_W_W-1:0]  width_r;
  logic [IMG_H_W-1:0]  height_r;

  logic [CW-1:0]        col_r;
  logic [CW-1:0]        col_nxt;
  logic [RW-1:0]        row_r;
  logic [RW-1:0]        row_nxt;
  logic [PIX_W-1:0]     px_r;
  logic [CW-1:0]        waddr_r;
  logic                 need_r;
  logic [OUT_COL_W-1:0] ocol_r;
  logic [OUT_ROW_W-1:0] orow_r;
  logic                 eof_r;

  logic                 out_valid_r;
  logic [PIX_W-1:0]     out_pix_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic                 out_eof_r;

  logic [31:0] w_eff;
  logic [31:0] h_eff;
  logic [31:0] ocol_full;
  logic [31:0] orow_full;
  logic        last_col;
  logic        last_row;
  logic        in_xfer;
  logic        out_free;

  logic                    in_ready;
  logic                    mem_wr;
  win_ctl_t                win_ctl;
  logic                    div_start;
  logic                    out_load;
  logic [LS_W-1:0]         ls_word;
  logic signed [SUM_W-1:0] mac_sum;
  logic                    mac_done;
  logic [PIX_W-1:0]        div_q;
  logic                    div_done;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '0;
      norm_r   <= NORM_W'(1);
      width_r  <= IMG_W_W'(5);
      height_r <= IMG_H_W'(5);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF0:  coef_r[0] <= cfg_wdata[COEF_W-1:0];
        REG_COEF1:  coef_r[1] <= cfg_wdata[COEF_W-1:0];
        REG_COEF2:  coef_r[2] <= cfg_wdata[COEF_W-1:0];
        REG_COEF3:  coef_r[3] <= cfg_wdata[COEF_W-1:0];
        REG_COEF4:  coef_r[4] <= cfg_wdata[COEF_W-1:0];
        REG_NORM:   norm_r    <= cfg_wdata[NORM_W-1:0];
        REG_WIDTH:  width_r   <= cfg_wdata[IMG_W_W-1:0];
        REG_HEIGHT: height_r  <= cfg_wdata[IMG_H_W-1:0];
      endcase
    end
  end

  // position of the incoming pixel
  always_comb begin
    w_eff = 32'(width_r);
    if (w_eff < 32'd5) w_eff = 32'd5;
    if (w_eff > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = 32'(height_r);
    if (h_eff < 32'd5) h_eff = 32'd5;
    if (h_eff > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
    last_col  = 32'(col_r) >= (w_eff - 32'd1);
    last_row  = 32'(row_r) >= (h_eff - 32'd1);
    ocol_full = 32'(col_r) - 32'd2;
    orow_full = 32'(row_r) - 32'd2;
    col_nxt   = last_col ? '0 : col_r + CW'(1);
    row_nxt   = row_r;
    if (last_col) begin
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end
  end

  assign in_xfer  = in_pix.valid && in_ready;
  assign out_free = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      need_r <= 1'b0;
    end else if (in_xfer) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      need_r <= (32'(row_r) >= 32'd4) && (32'(col_r) >= 32'd4);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      px_r    <= in_pix.pixel_in;
      waddr_r <= col_r;
      ocol_r  <= ocol_full[OUT_COL_W-1:0];
      orow_r  <= orow_full[OUT_ROW_W-1:0];
      eof_r   <= last_col && last_row;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_xfer) state_nxt = S_READ;
      S_READ: state_nxt = need_r ? S_MAC : S_IDLE;
      S_MAC:  if (mac_done) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = out_free ? S_IDLE : S_HOLD;
      S_HOLD: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    mem_wr        = 1'b0;
    win_ctl.shift = 1'b0;
    win_ctl.start = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_READ: begin
        mem_wr        = 1'b1;
        win_ctl.shift = 1'b1;
        win_ctl.start = need_r;
      end
      S_MAC:  div_start = mac_done;
      S_DIV:  out_load  = div_done && out_free;
      S_HOLD: out_load  = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_pix.ready = in_ready;

  conv5_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_r),
    .rd_data (ls_word),
    .wr_en   (mem_wr),
    .wr_addr (waddr_r),
    .wr_data ({ls_word[23:0], px_r})
  );

  conv5_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .ls_word (ls_word),
    .px      (px_r),
    .coef    (coef_r),
    .sum     (mac_sum),
    .done    (mac_done)
  );

  conv5_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .sum     (mac_sum),
    .divisor (norm_r),
    .q       (div_q),
    .done    (div_done)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix_r <= div_q;
      out_col_r <= ocol_r;
      out_row_r <= orow_r;
      out_eof_r <= eof_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.pixel_out    = out_pix_r;
  assign out_res.out_col      = out_col_r;
  assign out_res.out_row      = out_row_r;
  assign out_res.end_of_frame = out_eof_r;

`ifndef SYNTHESIS
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr |-> $past(in_xfer))
    else $error("line store written without a read one cycle before");

  a_mac_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_MAC)
    else $error("accumulator finished outside the accumulate state");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_res.ready))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire
